// File: sv/mre_pkg.sv
// Package for the metric record encoder: word types, request and value codes,
// status codes and the run descriptor passed from front to back. No dependencies.
`default_nettype none
package mre_pkg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  frame_version;
        logic [15:0] frame_sequence;
        logic [15:0] record_key;
        logic [7:0]  record_flag;
        logic [1:0]  value_kind;
        logic [63:0] number_bits;
        logic [31:0] string_length;
        logic [7:0]  payload_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic [1:0] status;
    } t_out_word;

    localparam int unsigned RUN_BYTES = 11;

    // One input word's output run, low byte first.
    typedef struct packed {
        logic [8*RUN_BYTES-1:0] bytes;
        logic [3:0]             count;
        logic [1:0]             status;
    } t_run;

    localparam logic [1:0] REQ_FRAME   = 2'd0;
    localparam logic [1:0] REQ_RECORD  = 2'd1;
    localparam logic [1:0] REQ_PAYLOAD = 2'd2;

    localparam logic [1:0] KIND_NULL   = 2'd0;
    localparam logic [1:0] KIND_NUMBER = 2'd1;
    localparam logic [1:0] KIND_STRING = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NULL_FLAG = 2'd1;
    localparam logic [1:0] ST_SEQUENCE  = 2'd2;

    localparam logic [3:0] TY_NULL  = 4'd0;
    localparam logic [3:0] TY_ZERO  = 4'd1;
    localparam logic [3:0] TY_ONE   = 4'd2;
    localparam logic [3:0] TY_INT8  = 4'd3;
    localparam logic [3:0] TY_INT16 = 4'd4;
    localparam logic [3:0] TY_INT32 = 4'd5;
    localparam logic [3:0] TY_DBL   = 4'd7;
    localparam logic [3:0] TY_STR8  = 4'd8;
    localparam logic [3:0] TY_STR16 = 4'd9;
    localparam logic [3:0] TY_STR32 = 4'd10;

    localparam logic [7:0] FLAG_WIDE_KEY = 8'h08;
    localparam logic [7:0] MAGIC_0 = 8'h57;
    localparam logic [7:0] MAGIC_1 = 8'h41;
    localparam logic [7:0] MAGIC_2 = 8'h4d;
    localparam logic [7:0] FRAME_ONE = 8'h01;

endpackage
`default_nettype wire

// File: sv/mre_front.sv
// Front of the metric record encoder: classify each input word and build its
// byte run; tracks pending payload bytes. Depends on mre_pkg.
`default_nettype none
module mre_front
    import mre_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_word i_word,
    output t_run          o_run
);

    logic [31:0] r_payload_left;
    logic [31:0] n_payload_left;

    logic        sgn;
    logic [10:0] ef;
    logic [51:0] mant;
    logic [10:0] e_full;
    logic [4:0]  e5;
    logic        is_zero, e_small, frac_zero, int_ok, is_min32;
    logic [51:0] frac_sh;
    logic [52:0] mag_sh;
    logic [30:0] mag;
    logic [31:0] iv;
    logic [3:0]  ty;
    logic [63:0] val;
    logic [3:0]  nval;
    logic [7:0]  h;
    logic        wide;
    logic [23:0] hdr;
    logic [87:0] rec_bytes;
    logic [3:0]  rec_count;

    always_comb begin
        sgn      = i_word.number_bits[63];
        ef       = i_word.number_bits[62:52];
        mant     = i_word.number_bits[51:0];
        e_full   = ef - 11'd1023;
        e5       = e_full[4:0];
        is_zero  = (ef == 11'd0) && (mant == 52'd0);
        e_small  = (ef >= 11'd1023) && (ef <= 11'd1053);
        frac_sh  = mant << e5;
        frac_zero = (frac_sh == 52'd0);
        int_ok   = e_small && frac_zero;
        mag_sh   = {1'b1, mant} >> (6'd52 - {1'b0, e5});
        mag      = mag_sh[30:0];
        iv       = sgn ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
        is_min32 = sgn && (ef == 11'd1054) && (mant == 52'd0);

        ty   = TY_NULL;
        val  = 64'd0;
        nval = 4'd0;
        unique case (i_word.value_kind)
            KIND_NUMBER: begin
                priority if (is_zero) begin
                    ty = TY_ZERO;
                end else if (int_ok && !sgn && mag == 31'd1) begin
                    ty = TY_ONE;
                end else if (int_ok && (mag < 31'd128 || (sgn && mag == 31'd128))) begin
                    ty = TY_INT8;  val = {32'd0, iv}; nval = 4'd1;
                end else if (int_ok && (mag < 31'd32768 || (sgn && mag == 31'd32768))) begin
                    ty = TY_INT16; val = {32'd0, iv}; nval = 4'd2;
                end else if (int_ok) begin
                    ty = TY_INT32; val = {32'd0, iv}; nval = 4'd4;
                end else if (is_min32) begin
                    ty = TY_INT32; val = 64'h0000_0000_8000_0000; nval = 4'd4;
                end else begin
                    ty = TY_DBL;   val = i_word.number_bits; nval = 4'd8;
                end
            end
            KIND_STRING: begin
                val = {32'd0, i_word.string_length};
                priority if (i_word.string_length < 32'd256) begin
                    ty = TY_STR8;  nval = 4'd1;
                end else if (i_word.string_length < 32'd65536) begin
                    ty = TY_STR16; nval = 4'd2;
                end else begin
                    ty = TY_STR32; nval = 4'd4;
                end
            end
            default: begin
                ty = TY_NULL;
            end
        endcase

        h    = i_word.record_flag | {ty, 4'd0};
        wide = (i_word.record_key[15:8] != 8'd0);
        hdr  = wide ? {i_word.record_key, h | FLAG_WIDE_KEY}
                    : {8'd0, i_word.record_key[7:0], h};
        rec_bytes = wide ? {val, hdr} : {8'd0, val, hdr[15:0]};
        rec_count = (wide ? 4'd3 : 4'd2) + nval;
    end

    always_comb begin
        n_payload_left = r_payload_left;
        o_run.bytes    = '0;
        o_run.count    = 4'd1;
        o_run.status   = ST_SEQUENCE;
        priority if (i_word.req_type == REQ_PAYLOAD) begin
            if (r_payload_left != 32'd0) begin
                o_run.bytes[7:0] = i_word.payload_byte;
                o_run.status     = ST_OK;
                n_payload_left   = r_payload_left - 32'd1;
            end
        end else if (i_word.req_type == REQ_FRAME && r_payload_left == 32'd0) begin
            o_run.bytes[63:0] = {8'd0, i_word.frame_sequence[7:0],
                                 i_word.frame_sequence[15:8], FRAME_ONE,
                                 i_word.frame_version, MAGIC_2, MAGIC_1, MAGIC_0};
            o_run.count  = 4'd8;
            o_run.status = ST_OK;
        end else if (i_word.req_type == REQ_RECORD && r_payload_left == 32'd0) begin
            if (i_word.value_kind == KIND_NULL && i_word.record_flag != 8'd0) begin
                o_run.status = ST_NULL_FLAG;
            end else if (i_word.value_kind == KIND_NULL ||
                         i_word.value_kind == KIND_NUMBER ||
                         i_word.value_kind == KIND_STRING) begin
                o_run.bytes  = rec_bytes;
                o_run.count  = rec_count;
                o_run.status = ST_OK;
                if (i_word.value_kind == KIND_STRING) begin
                    n_payload_left = i_word.string_length;
                end
            end
        end else begin
            o_run.status = ST_SEQUENCE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_left <= 32'd0;
        end else if (i_accept) begin
            r_payload_left <= n_payload_left;
        end
    end

endmodule
`default_nettype wire

// File: sv/mre_queue.sv
// Two-entry run queue between front and back of the metric record encoder.
// Depends on mre_pkg.
`default_nettype none
module mre_queue
    import mre_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_run i_run,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_run      o_run
);

    t_run       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_run   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

// File: sv/mre_back.sv
// Back of the metric record encoder: hold one run and shift its bytes out
// through the output register. Depends on mre_pkg.
`default_nettype none
module mre_back
    import mre_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    input  wire t_run  i_q_run,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_out_word  o_word
);

    logic                   r_valid;
    logic [8*RUN_BYTES-1:0] r_bytes;
    logic [3:0]             r_left;
    logic [1:0]             r_status;
    logic                   finishing;

    assign finishing = r_valid && i_ready && (r_left == 4'd1);
    assign o_pop     = i_q_valid && (!r_valid || finishing);

    assign o_valid            = r_valid;
    assign o_word.out_byte    = r_bytes[7:0];
    assign o_word.last_of_run = (r_left == 4'd1);
    assign o_word.status      = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= 4'd0;
        end else if (o_pop) begin
            r_valid  <= 1'b1;
            r_bytes  <= i_q_run.bytes;
            r_left   <= i_q_run.count;
            r_status <= i_q_run.status;
        end else if (r_valid && i_ready) begin
            // drop the sent byte
            if (r_left == 4'd1) begin
                r_valid <= 1'b0;
            end
            r_bytes <= {8'd0, r_bytes[8*RUN_BYTES-1:8]};
            r_left  <= r_left - 4'd1;
        end
    end

endmodule
`default_nettype wire

// File: sv/metric_record_encoder.sv
// Top level of the metric record encoder: front classifier, run queue and
// byte serializer. Depends on mre_pkg, mre_front, mre_queue, mre_back.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_word  (t_in_word)
//  out     | output    | o_out_valid / i_out_ready | o_out_word (t_out_word)
//
// Each input word is classified in the cycle it is taken and leaves a run of
// 1 to 11 output words (1 for payload bytes and errors, up to 11 for a
// wide-key double record); the back sends one word per cycle while the
// receiver is ready. Two runs buffer between front and back, so input is
// taken while the back still drains. Synchronous active-low reset
// clears the pending payload count, the queue and the output register.
`default_nettype none
module metric_record_encoder
    import mre_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    t_run front_run;
    t_run q_run;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic in_accept;

    // take a word whenever the queue has room
    assign o_in_ready = !q_full;
    assign in_accept  = i_in_valid && o_in_ready;

    mre_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (i_in_word),
        .o_run    (front_run)
    );

    mre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_run   (front_run),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_run   (q_run)
    );

    mre_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_run   (q_run),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_word    (o_out_word)
    );

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking bench for metric_record_encoder: drives random and directed
// request words, predicts the serialized bytes and checks every output word.
// Depends on mre_pkg and the encoder RTL.
`timescale 1ns / 100ps
`default_nettype none

import mre_pkg::*;

// Holds the expected byte stream and the pending-payload count of the encoder.
class frame_byte_board;
    t_out_word  pending_bytes[$];
    logic [31:0] strings_left;
    int          err_count;
    int          checked;

    function new();
        strings_left = '0;
        err_count = 0;
        checked = 0;
    endfunction

    function void add_word(t_out_word w);
        pending_bytes.insert(pending_bytes.size(), w);
    endfunction

    function void push(logic [7:0] b);
        t_out_word w;
        w.out_byte = b;
        w.last_of_run = 1'b0;
        w.status = ST_OK;
        add_word(w);
    endfunction

    function void push_error(logic [1:0] code);
        t_out_word w;
        w.out_byte = 8'h00;
        w.last_of_run = 1'b1;
        w.status = code;
        add_word(w);
    endfunction

    function void push_header(logic [15:0] key, logic [7:0] h);
        if (key < 16'd256) begin
            push(h);
            push(key[7:0]);
        end else begin
            push(h | FLAG_WIDE_KEY);
            push(key[7:0]);
            push(key[15:8]);
        end
    endfunction

    function void push_le(logic [63:0] v, int n);
        for (int i = 0; i < n; i++) push(v[8*i +: 8]);
    endfunction

    // Decode the double: finite and without fraction, and its integer value
    // when it fits in 34 signed bits (otherwise flagged as too large).
    function automatic bit whole_number(logic [63:0] bits, output longint ival,
                                        output bit fits);
        int unsigned ef;
        logic [52:0] m;
        int e;
        ef = {21'd0, bits[62:52]};
        ival = 0;
        fits = 1'b0;
        if (ef == 11'h7ff) return 1'b0;
        if (ef == 0) begin
            fits = 1'b1;
            return bits[51:0] == 0;
        end
        e = int'(ef) - 1023;
        if (e < 0) return 1'b0;
        if (e < 52 && (bits[51:0] & ((52'd1 << (52 - e)) - 1)) != 0) return 1'b0;
        if (e <= 32) begin
            m = {1'b1, bits[51:0]};
            ival = longint'(m >> (52 - e));
            if (bits[63]) ival = -ival;
            fits = 1'b1;
        end
        return 1'b1;
    endfunction

    // Note one accepted request word and queue the bytes it must produce.
    function void note_request(t_in_word w);
        longint iv;
        bit fits;
        bit whole;
        if (w.req_type == 2'd3) begin
            push_error(ST_SEQUENCE);
            return;
        end
        if (w.req_type == REQ_PAYLOAD) begin
            if (strings_left == 0) begin
                push_error(ST_SEQUENCE);
                return;
            end
            strings_left--;
            push(w.payload_byte);
        end else if (strings_left != 0) begin
            push_error(ST_SEQUENCE);
            return;
        end else if (w.req_type == REQ_FRAME) begin
            push(MAGIC_0); push(MAGIC_1); push(MAGIC_2);
            push(w.frame_version); push(FRAME_ONE);
            push(w.frame_sequence[15:8]); push(w.frame_sequence[7:0]);
            push(8'h00);
        end else if (w.value_kind == KIND_NULL) begin
            if (w.record_flag != 0) begin
                push_error(ST_NULL_FLAG);
                return;
            end
            push_header(w.record_key, {TY_NULL, 4'h0});
        end else if (w.value_kind == KIND_NUMBER) begin
            whole = whole_number(w.number_bits, iv, fits);
            if (whole && fits && iv == 0)
                push_header(w.record_key, w.record_flag | {TY_ZERO, 4'h0});
            else if (whole && fits && iv == 1)
                push_header(w.record_key, w.record_flag | {TY_ONE, 4'h0});
            else if (whole && fits && iv >= -128 && iv < 128) begin
                push_header(w.record_key, w.record_flag | {TY_INT8, 4'h0});
                push_le(64'(iv), 1);
            end else if (whole && fits && iv >= -32768 && iv < 32768) begin
                push_header(w.record_key, w.record_flag | {TY_INT16, 4'h0});
                push_le(64'(iv), 2);
            end else if (whole && fits && iv >= -64'sd2147483648 && iv < 64'sd2147483648)
            begin
                push_header(w.record_key, w.record_flag | {TY_INT32, 4'h0});
                push_le(64'(iv), 4);
            end else begin
                push_header(w.record_key, w.record_flag | {TY_DBL, 4'h0});
                push_le(w.number_bits, 8);
            end
        end else if (w.value_kind == KIND_STRING) begin
            if (w.string_length < 256) begin
                push_header(w.record_key, w.record_flag | {TY_STR8, 4'h0});
                push_le(64'(w.string_length), 1);
            end else if (w.string_length < 65536) begin
                push_header(w.record_key, w.record_flag | {TY_STR16, 4'h0});
                push_le(64'(w.string_length), 2);
            end else begin
                push_header(w.record_key, w.record_flag | {TY_STR32, 4'h0});
                push_le(64'(w.string_length), 4);
            end
            strings_left = w.string_length;
        end else begin
            push_error(ST_SEQUENCE);
            return;
        end
        pending_bytes[pending_bytes.size() - 1].last_of_run = 1'b1;
    endfunction

    // Compare one output word with the oldest expectation.
    function void check_word(t_out_word got);
        t_out_word want;
        checked++;
        if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected word byte=%h last=%b status=%0d",
                     $time, got.out_byte, got.last_of_run, got.status);
            err_count++;
            return;
        end
        want = pending_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
            err_count++;
        end
        if (got.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %b actual %b", $time,
                     want.last_of_run, got.last_of_run);
            err_count++;
        end
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            err_count++;
        end
    endfunction
endclass

module testbench;
    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    frame_byte_board board;
    int  words_sent;
    int  hold_off_cycles;   // receiver stall requested by the driver

    metric_record_encoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Note accepted words and check results at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            board.note_request(i_in_word);
            words_sent++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) board.check_word(o_out_word);
    end

    // Receiver: random stalls per word, plus a long hold-off on request.
    initial begin
        int gap;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge i_clk);
                hold_off_cycles = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (gap > 0 && $urandom_range(0, 1)) begin
                i_out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                // hold ready until one word leaves
                @(posedge i_clk);
                while (!o_out_valid) @(posedge i_clk);
            end
        end
    end

    // Offer one word and hold it until accepted; valid stays high into the
    // next word unless a gap drops it.
    task automatic send_word(t_in_word w, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_word <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid after the last offered word.
    task automatic idle_input();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_in_word noise_word();
        t_in_word w;
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(t_in_word)-1:0];
        return w;
    endfunction

    function automatic t_in_word frame_word();
        t_in_word w;
        w = noise_word();
        w.req_type = REQ_FRAME;
        return w;
    endfunction

    function automatic t_in_word record_word(logic [1:0] kind, logic [63:0] nb,
                                             logic [31:0] slen);
        t_in_word w;
        w = noise_word();
        w.req_type = REQ_RECORD;
        w.value_kind = kind;
        w.number_bits = nb;
        w.string_length = slen;
        w.record_key = $urandom_range(0, 1) ? 16'($urandom_range(0, 255)) : 16'($urandom);
        if (kind == KIND_NULL && $urandom_range(0, 3) != 0) w.record_flag = 8'h00;
        return w;
    endfunction

    function automatic t_in_word byte_word();
        t_in_word w;
        w = noise_word();
        w.req_type = REQ_PAYLOAD;
        return w;
    endfunction

    // A random double that lands in each encoding class with fair odds.
    function automatic logic [63:0] random_number();
        real r;
        case ($urandom_range(0, 7))
            0: r = 0.0;
            1: r = 1.0;
            2: r = real'($urandom_range(0, 255)) - 128.0;
            3: r = real'($urandom_range(0, 65535)) - 32768.0;
            4: r = real'($signed($urandom));
            5: r = real'($signed($urandom)) + 0.5;
            6: r = real'($signed($urandom)) * 4096.0;
            default: return {$urandom, $urandom};
        endcase
        return $realtobits(r);
    endfunction

    // Send a string record and all its payload bytes.
    task automatic send_string(logic [31:0] len);
        send_word(record_word(KIND_STRING, {$urandom, $urandom}, len), 1'b0);
        for (int i = 0; i < len; i++) send_word(byte_word(), ($urandom_range(0, 3) == 0));
    endtask

    task automatic wait_drained();
        while (board.pending_bytes.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_in_word w;
        board = new();
        words_sent = 0;
        hold_off_cycles = 0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: frame edges, null and every number class, 8- and 16-bit string lengths, and error paths.
        w = frame_word(); w.frame_version = 8'h00; w.frame_sequence = 16'h0000;
        send_word(w, 1'b0);
        w = frame_word(); w.frame_version = 8'hff; w.frame_sequence = 16'hffff;
        send_word(w, 1'b0);
        w = record_word(KIND_NULL, '0, '0); w.record_flag = 8'h00; w.record_key = 16'd255;
        send_word(w, 1'b0);
        w = record_word(KIND_NULL, '0, '0); w.record_flag = 8'h81;
        send_word(w, 1'b0);
        w = record_word(KIND_NUMBER, 64'h8000_0000_0000_0000, '0); w.record_key = 16'd256;
        send_word(w, 1'b0);
        send_word(record_word(KIND_NUMBER, $realtobits(1.0), '0), 1'b0);
        send_word(record_word(KIND_NUMBER, $realtobits(-128.0), '0), 1'b0);
        send_word(record_word(KIND_NUMBER, $realtobits(128.0), '0), 1'b0);
        send_word(record_word(KIND_NUMBER, $realtobits(-32768.0), '0), 1'b0);
        send_word(record_word(KIND_NUMBER, $realtobits(-2147483648.0), '0), 1'b0);
        send_word(record_word(KIND_NUMBER, $realtobits(2147483648.0), '0), 1'b0);
        send_word(record_word(KIND_NUMBER, 64'h7ff0_0000_0000_0000, '0), 1'b0);
        send_word(record_word(KIND_NUMBER, 64'hfff8_0000_0000_0001, '0), 1'b0);
        send_word(record_word(KIND_NUMBER, 64'h0000_0000_0000_0001, '0), 1'b0);
        send_word(record_word(KIND_NUMBER, $realtobits(0.5), '0), 1'b0);
        w = record_word(KIND_NUMBER, 64'hffff_ffff_ffff_ffff, '0); w.record_key = 16'hffff;
        w.record_flag = 8'hff;
        send_word(w, 1'b0);
        send_word(record_word(2'd3, '0, '0), 1'b0);
        w = noise_word(); w.req_type = 2'd3;
        send_word(w, 1'b0);
        send_word(byte_word(), 1'b0);
        send_string(0);
        send_string(2);
        send_word(record_word(KIND_STRING, '0, 32'd256), 1'b0);
        send_word(frame_word(), 1'b0);            // out of sequence mid-string
        for (int i = 0; i < 256; i++) send_word(byte_word(), 1'b1);

        // Receiver hold-off while the sender keeps offering words.
        hold_off_cycles = 200;
        for (int i = 0; i < 20; i++) send_word(record_word(KIND_NUMBER,
            {$urandom, $urandom}, '0), 1'b1);
        // Sender pauses until everything has come out.
        idle_input();
        wait_drained();

        // Random: mostly well-formed frames, records and strings, some noise.
        while (words_sent < 415) begin
            case ($urandom_range(0, 9))
                0: send_word(frame_word(), 1'b0);
                1, 2, 3: send_word(record_word(KIND_NUMBER, random_number(), '0), 1'b0);
                4: send_word(record_word(KIND_NULL, '0, '0), 1'b0);
                5, 6: send_string(32'($urandom_range(0, 12)));
                7: send_word(noise_word(), 1'b0);
                8: send_word(byte_word(), 1'b0);
                default: begin
                    // broken string: header, one byte, then an intruding frame and the rest
                    send_word(record_word(KIND_STRING, '0, 32'($urandom_range(3, 8))), 1'b0);
                    send_word(byte_word(), 1'b0);
                    send_word(frame_word(), 1'b0);
                    while (board.strings_left != 0) send_word(byte_word(), 1'b1);
                end
            endcase
        end

        // Close with a long string header: its payload stays pending, so the
        // frame after it is refused and a few bytes still pass.
        send_word(record_word(KIND_STRING, '0, 32'h8000_0000), 1'b0);
        send_word(frame_word(), 1'b0);
        for (int i = 0; i < 3; i++) send_word(byte_word(), 1'b0);
        idle_input();
        wait_drained();
        repeat (30) @(posedge i_clk);
        $display("Run covered %0d request words and %0d output words.",
                 words_sent, board.checked);
        if (board.err_count == 0 && board.pending_bytes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Give up after a generous fixed time.
    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: files.f
sv/mre_pkg.sv
sv/mre_front.sv
sv/mre_queue.sv
sv/mre_back.sv
sv/metric_record_encoder.sv
sim/testbench.sv
